// ===== design/a429_pkg.sv =====
// ARINC 429 label decoder package: label codes, decode classes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package a429_pkg;

  // decode classes
  localparam logic [4:0] K_NONE   = 5'd0;
  localparam logic [4:0] K_L007   = 5'd1;
  localparam logic [4:0] K_L010   = 5'd2;
  localparam logic [4:0] K_L012   = 5'd3;
  localparam logic [4:0] K_HDG10  = 5'd4;
  localparam logic [4:0] K_L015   = 5'd5;
  localparam logic [4:0] K_L016   = 5'd6;
  localparam logic [4:0] K_L351   = 5'd7;
  localparam logic [4:0] K_L265   = 5'd8;
  localparam logic [4:0] K_HDGB   = 5'd9;
  localparam logic [4:0] K_ANG    = 5'd10;
  localparam logic [4:0] K_L312   = 5'd11;
  localparam logic [4:0] K_L315   = 5'd12;
  localparam logic [4:0] K_S8     = 5'd13;
  localparam logic [4:0] K_L364   = 5'd14;
  localparam logic [4:0] K_S256   = 5'd15;
  localparam logic [4:0] K_L335   = 5'd16;
  localparam logic [4:0] K_L354   = 5'd17;
  localparam logic [4:0] K_L360   = 5'd18;
  localparam logic [4:0] K_L361   = 5'd19;
  localparam logic [4:0] K_L365   = 5'd20;

  localparam logic [1:0] ST_NCD  = 2'd1;
  localparam logic [1:0] ST_TEST = 2'd2;
  localparam logic [1:0] ST_NORM = 2'd3;

  localparam logic [1:0] ADD_NONE  = 2'd0;
  localparam logic [1:0] ADD_HDG   = 2'd1;
  localparam logic [1:0] ADD_PITCH = 2'd2;
  localparam logic [1:0] ADD_ROLL  = 2'd3;

  // correction register indexes
  localparam logic [1:0] REG_HDG   = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_ROLL  = 2'd2;

  // stage 1 -> stage 2: numerator n, exact value = n * mul / den
  typedef struct packed {
    logic              ok;
    logic signed [31:0] num;
    logic [20:0]       mul;   // unsigned multiplier
    logic [4:0]        kind;
    logic [1:0]        add;
    logic              wrap;
  } a429_s1_t;

  // stage 2 -> stage 3: product before rounding division
  typedef struct packed {
    logic              ok;
    logic signed [55:0] prod;
    logic [4:0]        kind;
    logic [1:0]        add;
    logic              wrap;
  } a429_s2_t;

  function automatic logic [4:0] kind_of(input logic [7:0] lbl);
    logic [4:0] k;
    begin
      unique case (lbl)
        8'o007: k = K_L007;
        8'o010, 8'o011: k = K_L010;
        8'o012: k = K_L012;
        8'o013, 8'o014, 8'o044: k = K_HDG10;
        8'o015: k = K_L015;
        8'o016: k = K_L016;
        8'o351: k = K_L351;
        8'o265: k = K_L265;
        8'o313, 8'o314, 8'o316: k = K_HDGB;
        8'o324, 8'o325, 8'o310, 8'o311, 8'o317, 8'o320, 8'o321, 8'o322, 8'o334:
          k = K_ANG;
        8'o312, 8'o366, 8'o367: k = K_L312;
        8'o315: k = K_L315;
        8'o323, 8'o331, 8'o332, 8'o333, 8'o362, 8'o363, 8'o370: k = K_S8;
        8'o364: k = K_L364;
        8'o326, 8'o327, 8'o330, 8'o336, 8'o337: k = K_S256;
        8'o335: k = K_L335;
        8'o354: k = K_L354;
        8'o360: k = K_L360;
        8'o361: k = K_L361;
        8'o365: k = K_L365;
        default: k = K_NONE;
      endcase
      return k;
    end
  endfunction

endpackage

// ===== design/arinc429_irs_label_decoder_unit.sv =====
// ARINC 429 IRS label decoder top level.
// Depends on a429_pkg, a429_front, a429_mult, a429_round.
`timescale 1ns / 1ps
// Usage:
//  - Input: drive in_word and pulse start; a transaction is taken at each
//    clock edge with start high and busy low. busy is tied low: the pipeline
//    accepts one word every cycle.
//  - Output: out_strobe is high for one cycle with out_value (Q31.16) and
//    out_valid_res. The receiver cannot stall; results must be captured.
//  - Pipeline: start to strobe passes through decode, multiply, round prep,
//    reciprocal partial products, sum and shift, correction/wrap registers.
//    Throughput: one word per cycle.
//  - Config: cfg_we with cfg_index 0/1/2 writes heading, pitch, roll
//    corrections (Q8.16 degrees); write only while the pipe is empty.
//  - Reset (rst_n low, synchronous) clears corrections and all valid bits.
//  - Invalid status (except for label 361) or unknown label gives out_valid_res 0, out_value 0.
module arinc429_irs_label_decoder_unit import a429_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_word,
  output logic               out_strobe,
  output logic signed [47:0] out_value,
  output logic               out_valid_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [24:0]        cfg_data
);

  logic signed [24:0] hdg_r, pitch_r, roll_r;
  logic s1_v, s2_v;
  a429_s1_t s1;
  a429_s2_t s2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdg_r <= '0; pitch_r <= '0; roll_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HDG) hdg_r <= cfg_data;
      if (cfg_index == REG_PITCH) pitch_r <= cfg_data;
      if (cfg_index == REG_ROLL) roll_r <= cfg_data;
    end
  end

  a429_front u_front (.clk, .rst_n, .in_v(start), .word(in_word), .s1_v_r(s1_v), .s1_r(s1));
  a429_mult  u_mult  (.clk, .rst_n, .s1_v, .s1, .s2_v_r(s2_v), .s2_r(s2));
  a429_round u_round (.clk, .rst_n, .s2_v, .s2, .hdg_corr(hdg_r), .pitch_corr(pitch_r),
                      .roll_corr(roll_r), .out_strobe_r(out_strobe),
                      .out_value_r(out_value), .out_valid_res_r(out_valid_res));

endmodule

// ===== design/a429_front.sv =====
// Stage 1: label classification, status check, BCD digit weighting, BNR field pick.
// Depends on a429_pkg.
`timescale 1ns / 1ps
module a429_front import a429_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  logic [31:0] word,
  output logic        s1_v_r,
  output a429_s1_t    s1_r
);

  a429_s1_t s1_nxt;

  function automatic logic signed [31:0] d(input logic [31:0] w, input int sh);
    return $signed({28'd0, w[sh +: 4]});
  endfunction

  always_comb begin
    logic [1:0] st;
    logic bcd_ok, neg, bnr_ok;
    logic signed [31:0] b21, b16, b22, t;
    st = word[30:29];
    bcd_ok = (st != ST_NCD) && (st != ST_TEST);
    neg = (st == ST_NORM);
    bnr_ok = (st == ST_NORM);
    b21 = {{11{word[28]}}, word[28:8]};
    b16 = {{16{word[28]}}, word[28:13]};
    b22 = {{10{word[28]}}, word[28:7]};
    t = '0;
    s1_nxt.kind = kind_of(word[7:0]);
    s1_nxt.ok = 1'b0;
    s1_nxt.num = '0;
    s1_nxt.mul = 21'd1;
    s1_nxt.add = ADD_NONE;
    s1_nxt.wrap = 1'b0;
    unique case (s1_nxt.kind)
      K_L007: begin
        s1_nxt.ok = bcd_ok; s1_nxt.num = d(word, 22) * 10 + d(word, 18);
      end
      K_L010: begin
        t = ((word[7:0] == 8'o011) ? $signed({31'd0, word[28]}) * 100 : 32'sd0)
            + d(word, 24) * 10 + d(word, 20);
        t = t * 600 + (d(word, 16) * 10 + d(word, 12)) * 10 + d(word, 8);
        s1_nxt.ok = bcd_ok; s1_nxt.num = neg ? -t : t;
      end
      K_L012: begin
        s1_nxt.ok = bcd_ok;
        s1_nxt.num = $signed({29'd0, word[28:26]}) * 1000 + d(word, 22) * 100
                     + d(word, 18) * 10 + d(word, 14);
      end
      K_HDG10: begin
        t = $signed({30'd0, word[27:26]}) * 1000 + d(word, 22) * 100
            + d(word, 18) * 10 + d(word, 14);
        s1_nxt.ok = bcd_ok; s1_nxt.num = neg ? 32'sd3600 - t : t;
      end
      K_L015: begin
        s1_nxt.ok = bcd_ok;
        s1_nxt.num = $signed({30'd0, word[27:26]}) * 100 + d(word, 22) * 10
                     + d(word, 18);
      end
      K_L016: begin
        t = $signed({30'd0, word[27:26]}) * 100 + d(word, 22) * 10 + d(word, 18);
        s1_nxt.ok = bcd_ok; s1_nxt.num = neg ? 32'sd360 - t : t;
      end
      K_L351: begin
        s1_nxt.ok = bcd_ok; s1_nxt.num = d(word, 18) * 10 + d(word, 14);
      end
      K_L265: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd3048; end
      K_HDGB: begin
        s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd45; s1_nxt.wrap = 1'b1;
        if (word[7:0] == 8'o314) s1_nxt.add = ADD_HDG;
      end
      K_ANG: begin
        s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd45;
        if (word[7:0] == 8'o324) s1_nxt.add = ADD_PITCH;
        if (word[7:0] == 8'o325) s1_nxt.add = ADD_ROLL;
      end
      K_L312: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd118528; end
      K_L315: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd3704; end
      K_S8:   begin s1_nxt.ok = bnr_ok; s1_nxt.num = b16; s1_nxt.mul = 21'd8; end
      K_L364: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b16; s1_nxt.mul = 21'd1569064; end
      K_S256: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b16; s1_nxt.mul = 21'd256; end
      K_L335: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd2; end
      K_L354: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b22; s1_nxt.mul = 21'd65536; end
      K_L360: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b16; s1_nxt.mul = 21'd381; end
      K_L361: begin s1_nxt.ok = 1'b1; s1_nxt.num = b21; s1_nxt.mul = 21'd381; end
      K_L365: begin s1_nxt.ok = bnr_ok; s1_nxt.num = b21; s1_nxt.mul = 21'd780288; end
      default: s1_nxt.ok = 1'b0;
    endcase
    // BCD scaled by Q_ONE and 463 where the label asks for it
    if (s1_nxt.kind == K_L007 || s1_nxt.kind == K_L010 || s1_nxt.kind == K_HDG10 ||
        s1_nxt.kind == K_L016 || s1_nxt.kind == K_L351)
      s1_nxt.mul = 21'd65536;
    if (s1_nxt.kind == K_L012 || s1_nxt.kind == K_L015)
      s1_nxt.mul = 21'd463;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= in_v;
    s1_r <= s1_nxt;
  end

endmodule

// ===== design/a429_mult.sv =====
// Stage 2: one signed-by-unsigned multiply of field by label coefficient.
// Depends on a429_pkg.
`timescale 1ns / 1ps
module a429_mult import a429_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s1_v,
  input  a429_s1_t s1,
  output logic     s2_v_r,
  output a429_s2_t s2_r
);

  a429_s2_t s2_nxt;

  always_comb begin
    s2_nxt.ok = s1.ok;
    s2_nxt.kind = s1.kind;
    s2_nxt.add = s1.add;
    s2_nxt.wrap = s1.wrap;
    s2_nxt.prod = 56'(s1.num) * $signed({35'd0, s1.mul});
    // L012, L015 and L360 need a further Q_ONE factor: exact shift
    if (s1.kind == K_L012 || s1.kind == K_L015 || s1.kind == K_L360)
      s2_nxt.prod = 56'(s1.num) * $signed({35'd0, s1.mul}) <<< 16;
    // L361 carries a further factor of 8192
    if (s1.kind == K_L361)
      s2_nxt.prod = 56'(s1.num) * $signed({35'd0, s1.mul}) <<< 13;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v;
    s2_r <= s2_nxt;
  end

endmodule

// ===== design/a429_round.sv =====
// Stage 3: round product by label divisor (reciprocal multiply), add correction,
// heading wrap, result register. Depends on a429_pkg.
`timescale 1ns / 1ps
module a429_round import a429_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s2_v,
  input  a429_s2_t           s2,
  input  logic signed [24:0] hdg_corr,
  input  logic signed [24:0] pitch_corr,
  input  logic signed [24:0] roll_corr,
  output logic               out_strobe_r,
  output logic signed [47:0] out_value_r,
  output logic               out_valid_res_r
);

  // Reciprocals: for x < 2**42, floor(x / d) == (x * RCP) >> SH
  // with SH = 42 + ceil(log2(d)) and RCP = ceil(2**SH / d).
  localparam logic [5:0]  SH_10    = 6'd46;
  localparam logic [5:0]  SH_600   = 6'd52;
  localparam logic [5:0]  SH_900   = 6'd52;
  localparam logic [5:0]  SH_1250  = 6'd53;
  localparam logic [5:0]  SH_20000 = 6'd57;
  localparam logic [5:0]  SH_75000 = 6'd59;
  localparam logic [42:0] RCP_10    = 43'(((64'd1 << 46) + 64'd9) / 64'd10);
  localparam logic [42:0] RCP_600   = 43'(((64'd1 << 52) + 64'd599) / 64'd600);
  localparam logic [42:0] RCP_900   = 43'(((64'd1 << 52) + 64'd899) / 64'd900);
  localparam logic [42:0] RCP_1250  = 43'(((64'd1 << 53) + 64'd1249) / 64'd1250);
  localparam logic [42:0] RCP_20000 = 43'(((64'd1 << 57) + 64'd19999) / 64'd20000);
  localparam logic [42:0] RCP_75000 = 43'(((64'd1 << 59) + 64'd74999) / 64'd75000);

  // stage 3a: magnitude plus half divisor, and reciprocal pick
  logic        v3_r, ok3_r, neg3_r, wrap3_r;
  logic [1:0]  add3_r;
  logic [41:0] mag3_r;
  logic [42:0] rcp3_r;
  logic [5:0]  sh3_r;
  // stage 3b: partial products
  logic        vp_r, okp_r, negp_r, wrapp_r;
  logic [1:0]  addp_r;
  logic [5:0]  shp_r;
  logic [41:0] pp_hh_r;
  logic [42:0] pp_hl_r;
  logic [41:0] pp_lh_r;
  logic [42:0] pp_ll_r;
  // stage 3c: quotient
  logic        v4_r, ok4_r, neg4_r, wrap4_r;
  logic [1:0]  add4_r;
  logic [41:0] q4_r;
  logic signed [47:0] r_nxt;

  always_ff @(posedge clk) begin
    logic [55:0] m;
    logic [16:0] dn;
    logic [42:0] rc;
    logic [5:0]  sh;
    m = s2.prod[55] ? 56'(-s2.prod) : s2.prod;
    unique case (s2.kind)
      K_L007, K_L351, K_HDG10: begin
        dn = 17'd10; rc = RCP_10; sh = SH_10;
      end
      K_L010: begin
        dn = 17'd600; rc = RCP_600; sh = SH_600;
      end
      K_L012, K_L015, K_L312, K_L315: begin
        dn = 17'd900; rc = RCP_900; sh = SH_900;
      end
      K_L265, K_L361: begin
        dn = 17'd1250; rc = RCP_1250; sh = SH_1250;
      end
      K_L364: begin
        dn = 17'd20000; rc = RCP_20000; sh = SH_20000;
      end
      K_L360, K_L365: begin
        dn = 17'd75000; rc = RCP_75000; sh = SH_75000;
      end
      K_HDGB, K_ANG: begin
        dn = 17'd4; rc = 43'd1; sh = 6'd2;
      end
      default: begin
        dn = 17'd1; rc = 43'd1; sh = 6'd0;
      end
    endcase
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= s2_v;
    ok3_r <= s2.ok; neg3_r <= s2.prod[55]; wrap3_r <= s2.wrap; add3_r <= s2.add;
    mag3_r <= m[41:0] + 42'(dn >> 1); rcp3_r <= rc; sh3_r <= sh;
  end

  // stage 3b: four partial products (21x21 and 21x22) of magnitude by reciprocal
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= v3_r;
    okp_r <= ok3_r; negp_r <= neg3_r; wrapp_r <= wrap3_r; addp_r <= add3_r;
    shp_r <= sh3_r;
    pp_hh_r <= 42'(mag3_r[41:21]) * 42'(rcp3_r[42:22]);
    pp_hl_r <= 43'(mag3_r[41:21]) * 43'(rcp3_r[21:0]);
    pp_lh_r <= 42'(mag3_r[20:0]) * 42'(rcp3_r[42:22]);
    pp_ll_r <= 43'(mag3_r[20:0]) * 43'(rcp3_r[21:0]);
  end

  // stage 3c: sum partial products, shift out the fraction
  always_ff @(posedge clk) begin
    logic [85:0] acc;
    acc = 86'({pp_hh_r, 43'd0}) + 86'({pp_hl_r, 21'd0}) + 86'({pp_lh_r, 22'd0})
          + 86'(pp_ll_r);
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= vp_r;
    ok4_r <= okp_r; neg4_r <= negp_r; wrap4_r <= wrapp_r; add4_r <= addp_r;
    q4_r <= 42'(acc >> shp_r);
  end

  always_comb begin
    logic signed [47:0] r, c;
    r = neg4_r ? -$signed({6'd0, q4_r}) : $signed({6'd0, q4_r});
    unique case (add4_r)
      ADD_HDG:   c = 48'(hdg_corr);
      ADD_PITCH: c = 48'(pitch_corr);
      ADD_ROLL:  c = 48'(roll_corr);
      default:   c = '0;
    endcase
    r = r + c;
    if (wrap4_r) begin
      if (r > 48'sd23592960) r = r - 48'sd23592960;
      if (r < 0) r = r + 48'sd23592960;
    end
    r_nxt = ok4_r ? r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= v4_r;
    out_value_r <= r_nxt;
    out_valid_res_r <= ok4_r;
  end

endmodule
